>>> rtl/dht_pkg.sv
// dht_pkg: types, constants and reduction helpers for the double hash key table.
// Used by dht_ctrl, dht_datapath and double_hash_key_table_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dht_pkg;

    // Table geometry
    localparam int SLOTS      = 16;
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int KEY_W      = 31;
    localparam int OCC_W      = 5;
    localparam int STRIDE_MOD = 7;

    // Key folding, one byte per cycle, most significant byte first
    localparam int KEY_BYTES  = (KEY_W + 7) / 8;
    localparam int KEY_PAD_W  = KEY_BYTES * 8;
    localparam int BYTE_IDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int RED_W      = IDX_W + 8;
    localparam int RED7_W     = 3 + 8;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SEARCH = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2,
        ST_BAD     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_LIVE  = 2'd1,
        TAG_TOMB  = 2'd2
    } t_tag;

    typedef enum logic [1:0] {
        S_CLEAR  = 2'd0,
        S_IDLE   = 2'd1,
        S_REDUCE = 2'd2,
        S_PROBE  = 2'd3
    } t_state;

    typedef struct packed {
        logic [1:0]       action;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] key_out;
        logic [OCC_W-1:0] occupied;
    } t_rsp;

    typedef struct packed {
        t_tag             tag;
        logic [KEY_W-1:0] key;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic reduce;
        logic probe;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic quick;
        logic clear_last;
        logic reduce_last;
        logic probe_done;
    } t_sts;

    // Restoring reduction of a value below 256*SLOTS to its residue mod SLOTS
    function automatic logic [IDX_W-1:0] mod_slots(input logic [RED_W-1:0] value);
        logic [RED_W-1:0] v;
        logic [RED_W-1:0] m;
        v = value;
        for (int k = 7; k >= 0; k--) begin
            m = RED_W'(SLOTS) << k;
            if (v >= m) begin
                v = v - m;
            end
        end
        return v[IDX_W-1:0];
    endfunction

    // Restoring reduction of a value below 256*7 to its residue mod 7
    function automatic logic [2:0] mod_seven(input logic [RED7_W-1:0] value);
        logic [RED7_W-1:0] v;
        logic [RED7_W-1:0] m;
        v = value;
        for (int k = 7; k >= 0; k--) begin
            m = RED7_W'(STRIDE_MOD) << k;
            if (v >= m) begin
                v = v - m;
            end
        end
        return v[2:0];
    endfunction

    // Probe stride (7 - key mod 7), taken mod SLOTS
    function automatic logic [IDX_W-1:0] stride_slots(input logic [2:0] rem7);
        logic [2:0] s;
        s = 3'(STRIDE_MOD) - rem7;
        return mod_slots(RED_W'(s));
    endfunction

endpackage

`default_nettype wire

>>> rtl/dht_ctrl.sv
// dht_ctrl: sequencer for the double hash key table (clear, idle, fold, probe).
// Depends on dht_pkg; drives the command struct of dht_datapath.
`timescale 1ns / 1ps
`default_nettype none

module dht_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  dht_pkg::t_sts i_sts,
    output dht_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import dht_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start && !i_sts.quick) begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (i_sts.reduce_last) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (i_sts.probe_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_cmd.accept = i_start;
                o_busy       = 1'b0;
            end
            S_REDUCE: begin
                o_cmd.reduce = 1'b1;
            end
            S_PROBE: begin
                o_cmd.probe = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    // The clearing sweep runs once after reset and never again
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |=> (r_state != S_CLEAR))
        else $error("table clear re-entered outside reset");

    // A request that bypasses the probe loop is answered without leaving idle
    a_quick_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start && i_sts.quick) |=> (r_state == S_IDLE))
        else $error("rejected request entered the probe sequence");

endmodule

`default_nettype wire

>>> rtl/dht_datapath.sv
// dht_datapath: slot memory, key folding, probe sequence arithmetic and result register.
// Depends on dht_pkg; steered by the command struct from dht_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module dht_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dht_pkg::t_req i_req,
    input  dht_pkg::t_cmd i_cmd,
    output dht_pkg::t_sts o_sts,
    output logic          o_strobe,
    output dht_pkg::t_rsp o_rsp
);
    import dht_pkg::*;

    // Slot memory, one entry per slot
    t_entry mem [SLOTS];
    t_entry r_rd;

    t_req                  r_req;
    logic [KEY_PAD_W-1:0]  r_shift;
    logic [BYTE_IDX_W-1:0] r_byte;
    logic [IDX_W-1:0]      r_first;
    logic [IDX_W-1:0]      r_acc;
    logic [2:0]            r_r7;
    logic [CNT_W-1:0]      r_issue;
    logic                  r_chk_vld;
    logic                  r_chk_last;
    logic [IDX_W-1:0]      r_chk_slot;
    logic [IDX_W-1:0]      r_clr;
    logic [CNT_W-1:0]      r_live;
    logic                  r_strobe;
    t_rsp                  r_rsp;

    logic [CNT_W-1:0] n_live;
    logic [IDX_W-1:0] n_first;
    logic [IDX_W-1:0] n_acc;
    logic [IDX_W:0]   slot_sum;
    logic [IDX_W:0]   first_inc;
    logic [IDX_W:0]   acc_sum;
    logic [IDX_W-1:0] stride_m;
    logic [IDX_W-1:0] addr;
    logic [7:0]       key_byte;
    logic             bad;
    logic             full;
    logic             quick;
    logic             issue;
    logic             is_ins;
    logic             is_rem;
    logic             hit;
    logic             miss;
    logic             done;
    logic             we;
    logic [IDX_W-1:0] waddr;
    t_entry           wdata;

    // Requests answered at once: bad key or action, or insert into a full table
    always_comb begin
        bad   = (i_req.key == '0) ||
                !(i_req.action inside {ACT_INSERT, ACT_REMOVE, ACT_SEARCH});
        full  = (i_req.action == ACT_INSERT) && (r_live >= CNT_W'(SLOTS));
        quick = bad || full;
    end

    // Probe address and next-probe arithmetic
    always_comb begin
        key_byte  = r_shift[KEY_PAD_W-1 -: 8];
        stride_m  = stride_slots(r_r7);
        slot_sum  = {1'b0, r_first} + {1'b0, r_acc};
        addr      = (slot_sum >= (IDX_W+1)'(SLOTS)) ?
                    IDX_W'(slot_sum - (IDX_W+1)'(SLOTS)) : slot_sum[IDX_W-1:0];
        first_inc = {1'b0, r_first} + (IDX_W+1)'(1);
        n_first   = (first_inc == (IDX_W+1)'(SLOTS)) ? '0 : first_inc[IDX_W-1:0];
        acc_sum   = {1'b0, r_acc} + {1'b0, stride_m};
        n_acc     = (acc_sum >= (IDX_W+1)'(SLOTS)) ?
                    IDX_W'(acc_sum - (IDX_W+1)'(SLOTS)) : acc_sum[IDX_W-1:0];
        issue     = i_cmd.probe && (r_issue < CNT_W'(SLOTS));
    end

    // Decide on the slot read in the previous cycle
    always_comb begin
        is_ins = (r_req.action == ACT_INSERT);
        is_rem = (r_req.action == ACT_REMOVE);
        hit    = is_ins ? (r_rd.tag != TAG_LIVE)
                        : ((r_rd.tag == TAG_LIVE) && (r_rd.key == r_req.key));
        miss   = !is_ins && (r_rd.tag == TAG_EMPTY);
        done   = i_cmd.probe && r_chk_vld && (hit || miss || r_chk_last);
    end

    always_comb begin
        we     = 1'b0;
        waddr  = r_chk_slot;
        wdata  = r_rd;
        n_live = r_live;
        if (i_cmd.clear) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = '{tag: TAG_EMPTY, key: '0};
        end else if (done && hit && is_ins) begin
            we     = 1'b1;
            wdata  = '{tag: TAG_LIVE, key: r_req.key};
            n_live = r_live + CNT_W'(1);
        end else if (done && hit && is_rem) begin
            we     = 1'b1;
            wdata  = '{tag: TAG_TOMB, key: r_rd.key};
            n_live = r_live - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_live    <= '0;
            r_chk_vld <= 1'b0;
            r_strobe  <= 1'b0;
            r_byte    <= '0;
            r_issue   <= '0;
        end else begin
            r_live    <= n_live;
            r_chk_vld <= issue && !done;
            r_strobe  <= (i_cmd.accept && quick) || done;
            if (i_cmd.clear) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (i_cmd.accept) begin
                r_byte  <= '0;
                r_issue <= '0;
            end else begin
                if (i_cmd.reduce) begin
                    r_byte <= r_byte + BYTE_IDX_W'(1);
                end
                if (issue) begin
                    r_issue <= r_issue + CNT_W'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req   <= i_req;
            r_shift <= KEY_PAD_W'(i_req.key);
            r_first <= '0;
            r_acc   <= '0;
            r_r7    <= '0;
        end else if (i_cmd.reduce) begin
            r_shift <= r_shift << 8;
            r_first <= mod_slots({r_first, key_byte});
            r_r7    <= mod_seven({r_r7, key_byte});
        end else if (issue) begin
            r_first <= n_first;
            r_acc   <= n_acc;
        end
        r_chk_slot <= addr;
        r_chk_last <= (r_issue == CNT_W'(SLOTS - 1));

        if (i_cmd.accept && quick) begin
            r_rsp.status   <= bad ? ST_BAD : ST_FULL;
            r_rsp.key_out  <= '0;
            r_rsp.occupied <= OCC_W'(r_live);
        end else if (done) begin
            r_rsp.status   <= hit ? ST_OK : (is_ins ? ST_FULL : ST_MISSING);
            r_rsp.key_out  <= hit ? r_req.key : '0;
            r_rsp.occupied <= OCC_W'(n_live);
        end
    end

    always_comb begin
        o_sts.quick       = quick;
        o_sts.clear_last  = (r_clr == IDX_W'(SLOTS - 1));
        o_sts.reduce_last = (r_byte == BYTE_IDX_W'(KEY_BYTES - 1));
        o_sts.probe_done  = done;
        o_strobe          = r_strobe;
        o_rsp             = r_rsp;
    end

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CNT_W'(SLOTS))
        else $error("live key count above table size");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_rsp.status == ST_OK && r_req.action == ACT_INSERT)
        |-> (r_live == $past(r_live) + CNT_W'(1)))
        else $error("successful insert did not raise the live count");

    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.probe |-> ({1'b0, r_first} < (IDX_W+1)'(SLOTS) &&
                         {1'b0, r_acc} < (IDX_W+1)'(SLOTS)))
        else $error("probe offsets left the table range");

endmodule

`default_nettype wire

>>> rtl/double_hash_key_table_core.sv
// double_hash_key_table_core: top level of the double hash key table.
// Depends on dht_pkg, dht_ctrl and dht_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Request channel: drive i_req (action, key) and raise i_start; the request is
//   taken at a rising edge where i_start is high and o_busy is low.
//   Result channel: each request gives one result on o_rsp (status, key_out,
//   occupied), shown for exactly one cycle with o_strobe high. The receiver
//   cannot stall it; capture it in the strobe cycle.
//   Answers: a bad key or action, or an insert into a full table, is answered
//   in the cycle after acceptance and o_busy stays low. Any other request
//   first folds the key (one byte a cycle against the table size and against
//   7), then probes one slot a cycle, each probe checked after the registered
//   slot memory read, until a hit, a miss or the last slot. The result strobes
//   in the first cycle with o_busy low again, and a new request may be taken
//   in that same cycle.
//   Throughput: no new request is taken before a probed one has its result;
//   quick answers allow one request a cycle.
//   Reset: i_rst_n is synchronous, active low. After it the block sweeps the
//   slot memory marking every slot empty, one slot a cycle, with o_busy high;
//   requests are taken once the sweep ends.
module double_hash_key_table_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  dht_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_strobe,
    output dht_pkg::t_rsp o_rsp
);
    import dht_pkg::*;

    // Command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // Sequence clear, key folding and probing
    dht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // Hold the slot memory, the probe arithmetic and the result register
    dht_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

endmodule

`default_nettype wire
